/* hw/rtl/clr_pkg.sv */
// Shared types and constants of the clipped line rasterizer.
package clr_pkg;

  // Field widths fixed by the command, result and configuration formats.
  localparam int CoordW  = 16;
  localparam int CmdW    = 2;
  localparam int CfgW    = 9;
  localparam int CfgIdxW = 1;

  // Default framebuffer size.
  localparam int MaxWDefault = 256;
  localparam int MaxHDefault = 256;

  // Register reset values.
  localparam logic [CfgW-1:0] ScreenWidthReset  = CfgW'(256);
  localparam logic [CfgW-1:0] ScreenHeightReset = CfgW'(256);

  // Register indexes on the configuration port.
  localparam logic [CfgIdxW-1:0] RegScreenWidth  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegScreenHeight = CfgIdxW'(1);

  // Command codes.
  typedef enum logic [CmdW-1:0] {
    CMD_SET_POINT  = 2'd0,
    CMD_DRAW_LINE  = 2'd1,
    CMD_CLEAR_ALL  = 2'd2,
    CMD_READ_PIXEL = 2'd3
  } clr_cmd_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_SETUP_A,
    ST_SETUP_B,
    ST_WALK,
    ST_SWEEP,
    ST_READ,
    ST_FINISH
  } clr_state_e;

endpackage

/* hw/rtl/clr_if.sv */
// Handshake interfaces for the command and result channels.
interface clr_cmd_if;
  logic                              valid;
  logic                              ready;
  logic [clr_pkg::CmdW-1:0]          command;
  logic signed [clr_pkg::CoordW-1:0] start_x;
  logic signed [clr_pkg::CoordW-1:0] start_y;
  logic signed [clr_pkg::CoordW-1:0] end_x;
  logic signed [clr_pkg::CoordW-1:0] end_y;

  modport source (output valid, command, start_x, start_y, end_x, end_y, input ready);
  modport sink   (input valid, command, start_x, start_y, end_x, end_y, output ready);
endinterface

interface clr_res_if;
  logic valid;
  logic ready;
  logic pixel_value;
  logic done_res;

  modport source (output valid, pixel_value, done_res, input ready);
  modport sink   (input valid, pixel_value, done_res, output ready);
endinterface

/* hw/rtl/clipped_line_rasterizer.sv */
// Clipped line rasterizer: one-bit framebuffer with point, line, clear and read commands.
//
//   Channel  | Dir | Contents
//   ---------+-----+----------------------------------------------------------
//   cmd_i    | in  | command, start_x, start_y, end_x, end_y (valid/ready)
//   res_o    | out | pixel_value, done_res (valid/ready)
//   cfg_*_i  | in  | write enable, register index, write data (no read-back)
//
// The framebuffer is one memory of MAX_H rows by MAX_W bits; every plotted pixel
// is a read of its row, a bit set and a write back, one pixel per cycle.
// A line passes through the setup states SETUP_A and SETUP_B, walks at most
// |dx|+|dy|+1 pixels and then finishes; a set point is a one-pixel line, a read
// passes through READ, and a clear sweeps all MAX_H rows before it finishes.
// After reset a sweep zeroes all MAX_H rows; no command is taken meanwhile.
// The result sits in an output register, so a stalled result only holds the next
// command once that command has finished.
module clipped_line_rasterizer #(
  parameter int MAX_W = clr_pkg::MaxWDefault,
  parameter int MAX_H = clr_pkg::MaxHDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  clr_cmd_if.sink                     cmd_i,
  clr_res_if.source                   res_o,
  input  logic                        cfg_we_i,
  input  logic [clr_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [clr_pkg::CfgW-1:0]    cfg_data_i
);
  import clr_pkg::*;

  localparam int ColW = (MAX_W > 1) ? $clog2(MAX_W) : 1;
  localparam int RowW = (MAX_H > 1) ? $clog2(MAX_H) : 1;
  localparam int DW   = CoordW + 1;   // coordinate differences and clip limits
  localparam int EW   = CoordW + 5;   // error term and its constants
  localparam int LW   = CoordW + 2;   // pixel budget of one line

  localparam logic [DW-1:0]          MaxWLim = DW'(MAX_W);
  localparam logic [DW-1:0]          MaxHLim = DW'(MAX_H);
  localparam logic [RowW-1:0]        LastRow = RowW'(MAX_H - 1);
  localparam logic signed [CoordW-1:0] StepPos = CoordW'(1);
  localparam logic signed [CoordW-1:0] StepNeg = '1;

  // True when (x, y) lies inside the clipped screen.
  function automatic logic in_view(input logic signed [CoordW-1:0] x,
                                   input logic signed [CoordW-1:0] y,
                                   input logic [DW-1:0] wl,
                                   input logic [DW-1:0] hl);
    return !x[CoordW-1] && ({1'b0, x} < wl) && !y[CoordW-1] && ({1'b0, y} < hl);
  endfunction

  // Control state.
  clr_state_e state_q, state_d;
  logic [RowW-1:0] sweep_q;
  logic            s1_valid_q;
  logic            res_valid_q;
  logic [CfgW-1:0] width_q, height_q;

  // Command and walk registers.
  logic signed [CoordW-1:0] cur_x_q, cur_y_q, end_x_q, end_y_q;
  logic signed [DW-1:0]     dx_q, dy_q;
  logic [CoordW-1:0]        a_q, b_q;
  logic                     sx_neg_q, sy_neg_q, steep_q;
  logic signed [EW-1:0]     e_q, crit_q, thr_q, dab_q, neg2a_q;
  logic [LW-1:0]            left_q;
  logic                     rd_vis_q, pix_q, res_pixel_q;
  logic [ColW-1:0]          rd_col_q, s1_col_q;
  logic [RowW-1:0]          s1_row_q;

  // Framebuffer memory and its forwarding path.
  logic [MAX_W-1:0] row_mem [MAX_H];
  logic [MAX_W-1:0] rd_data_q, fwd_data_q, base_row;
  logic             fwd_hit_q;

  // Control outputs of the sequencer.
  logic             cmd_ready;
  logic             cmd_accept;
  logic             res_load;
  logic             mem_we, mem_re;
  logic [RowW-1:0]  mem_waddr, mem_raddr;
  logic [MAX_W-1:0] mem_wdata;

  // Walk arithmetic.
  logic [DW-1:0]        w_lim, h_lim;
  logic                 cur_vis, start_vis, walk_last, x_step, y_step;
  logic signed [EW-1:0] a_ext, b2_ext, e_inc;
  logic signed [CoordW-1:0] sel_end_x, sel_end_y;

  // Clip limits: the smaller of the register and the store size.
  assign w_lim = (DW'(width_q) < MaxWLim) ? DW'(width_q) : MaxWLim;
  assign h_lim = (DW'(height_q) < MaxHLim) ? DW'(height_q) : MaxHLim;

  assign cur_vis   = in_view(cur_x_q, cur_y_q, w_lim, h_lim);
  assign start_vis = in_view(cmd_i.start_x, cmd_i.start_y, w_lim, h_lim);
  assign walk_last = ((cur_x_q == end_x_q) && (cur_y_q == end_y_q)) || (left_q == LW'(1));

  // A set point is a line whose end is its start.
  assign sel_end_x = (clr_cmd_e'(cmd_i.command) == CMD_SET_POINT) ? cmd_i.start_x : cmd_i.end_x;
  assign sel_end_y = (clr_cmd_e'(cmd_i.command) == CMD_SET_POINT) ? cmd_i.start_y : cmd_i.end_y;

  // Step decisions; the y test after an x step is folded into a precomputed threshold.
  assign a_ext  = $signed({{(EW - CoordW){1'b0}}, a_q});
  assign b2_ext = $signed({{(EW - CoordW - 1){1'b0}}, b_q, 1'b0});
  assign x_step = (e_q <= crit_q);
  assign y_step = steep_q || (x_step ? (e_q >= thr_q) : (e_q >= a_ext));

  always_comb begin
    unique case ({x_step, y_step})
      2'b11:   e_inc = dab_q;
      2'b10:   e_inc = b2_ext;
      2'b01:   e_inc = neg2a_q;
      default: e_inc = '0;
    endcase
  end

  // Row as seen by the modify stage, including a write at the read's own edge.
  assign base_row = fwd_hit_q ? fwd_data_q : rd_data_q;

  assign cmd_accept = cmd_i.valid && cmd_ready;

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_INIT: begin
        if (sweep_q == LastRow) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (cmd_accept) begin
          unique case (clr_cmd_e'(cmd_i.command))
            CMD_SET_POINT,
            CMD_DRAW_LINE:  state_d = ST_SETUP_A;
            CMD_CLEAR_ALL:  state_d = ST_SWEEP;
            CMD_READ_PIXEL: state_d = ST_READ;
          endcase
        end
      end
      ST_SETUP_A: state_d = ST_SETUP_B;
      ST_SETUP_B: state_d = ST_WALK;
      ST_WALK: begin
        if (walk_last) state_d = ST_FINISH;
      end
      ST_SWEEP: begin
        if (sweep_q == LastRow) state_d = ST_FINISH;
      end
      ST_READ: state_d = ST_FINISH;
      ST_FINISH: begin
        if (!res_valid_q || res_o.ready) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs: handshake and memory port control.
  always_comb begin
    cmd_ready = 1'b0;
    res_load  = 1'b0;
    mem_re    = 1'b0;
    mem_raddr = cur_y_q[RowW-1:0];
    mem_we    = 1'b0;
    mem_waddr = s1_row_q;
    mem_wdata = base_row | (MAX_W'(1) << s1_col_q);
    unique case (state_q)
      ST_INIT, ST_SWEEP: begin
        mem_we    = 1'b1;
        mem_waddr = sweep_q;
        mem_wdata = '0;
      end
      ST_IDLE: begin
        cmd_ready = 1'b1;
        mem_re    = cmd_accept && (clr_cmd_e'(cmd_i.command) == CMD_READ_PIXEL) && start_vis;
        mem_raddr = cmd_i.start_y[RowW-1:0];
      end
      ST_WALK: begin
        mem_re = cur_vis;
      end
      ST_FINISH: begin
        res_load = !res_valid_q || res_o.ready;
      end
      default: ;
    endcase
    // The modify stage writes back whenever it holds a pixel.
    if (s1_valid_q) mem_we = 1'b1;
  end

  assign cmd_i.ready       = cmd_ready;
  assign res_o.valid       = res_valid_q;
  assign res_o.pixel_value = res_pixel_q;
  assign res_o.done_res    = 1'b1;

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      sweep_q     <= '0;
      s1_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      s1_valid_q <= (state_q == ST_WALK) && cur_vis;
      if (state_q == ST_INIT || state_q == ST_SWEEP) begin
        sweep_q <= (sweep_q == LastRow) ? '0 : sweep_q + RowW'(1);
      end
      if (res_load) begin
        res_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // Configuration registers; the stored pixels are kept across writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= ScreenWidthReset;
      height_q <= ScreenHeightReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegScreenWidth:  width_q  <= cfg_data_i;
        RegScreenHeight: height_q <= cfg_data_i;
      endcase
    end
  end

  // Command capture, line setup and the walk itself.
  always_ff @(posedge clk_i) begin
    if (res_load) res_pixel_q <= pix_q;
    s1_row_q <= cur_y_q[RowW-1:0];
    s1_col_q <= cur_x_q[ColW-1:0];
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_accept) begin
          cur_x_q  <= cmd_i.start_x;
          cur_y_q  <= cmd_i.start_y;
          end_x_q  <= sel_end_x;
          end_y_q  <= sel_end_y;
          dx_q     <= $signed({sel_end_x[CoordW-1], sel_end_x})
                    - $signed({cmd_i.start_x[CoordW-1], cmd_i.start_x});
          dy_q     <= $signed({sel_end_y[CoordW-1], sel_end_y})
                    - $signed({cmd_i.start_y[CoordW-1], cmd_i.start_y});
          rd_vis_q <= start_vis;
          rd_col_q <= cmd_i.start_x[ColW-1:0];
          pix_q    <= 1'b0;
        end
      end
      ST_SETUP_A: begin
        a_q      <= dx_q[DW-1] ? CoordW'(-dx_q) : CoordW'(dx_q);
        b_q      <= dy_q[DW-1] ? CoordW'(-dy_q) : CoordW'(dy_q);
        sx_neg_q <= dx_q[DW-1];
        sy_neg_q <= dy_q[DW-1];
      end
      ST_SETUP_B: begin
        crit_q  <= $signed({a_ext[EW-2:0], 1'b0}) - $signed(b2_ext >>> 1);
        thr_q   <= a_ext - b2_ext;
        dab_q   <= b2_ext - $signed({a_ext[EW-2:0], 1'b0});
        neg2a_q <= -$signed({a_ext[EW-2:0], 1'b0});
        left_q  <= LW'(a_q) + LW'(b_q) + LW'(1);
        steep_q <= a_q < b_q;
        e_q     <= '0;
      end
      ST_WALK: begin
        if (!walk_last) begin
          if (x_step) cur_x_q <= cur_x_q + (sx_neg_q ? StepNeg : StepPos);
          if (y_step) cur_y_q <= cur_y_q + (sy_neg_q ? StepNeg : StepPos);
          e_q    <= e_q + e_inc;
          left_q <= left_q - LW'(1);
        end
      end
      ST_READ: begin
        pix_q <= rd_vis_q && base_row[rd_col_q];
      end
      default: ;
    endcase
  end

  // Framebuffer rows: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (mem_we) row_mem[mem_waddr] <= mem_wdata;
    if (mem_re) rd_data_q <= row_mem[mem_raddr];
    fwd_hit_q  <= mem_re && mem_we && (mem_waddr == mem_raddr);
    fwd_data_q <= mem_wdata;
  end

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the clipped line rasterizer: random commands, framebuffer predictor.
`timescale 1ns / 1ps

module tb_top;
  import clr_pkg::*;

  localparam int FrameW      = MaxWDefault;
  localparam int FrameH      = MaxHDefault;
  localparam int CycleLimit  = 5_000_000;
  localparam int DrainCycles = 2 * FrameH;
  localparam int NumPhases   = 6;
  localparam int MaxReports  = 10;

  typedef struct packed {
    clr_cmd_e          cmd;
    logic [CoordW-1:0] sx;
    logic [CoordW-1:0] sy;
    logic [CoordW-1:0] ex;
    logic [CoordW-1:0] ey;
  } raster_cmd_t;

  typedef struct packed {
    logic pixel;
    logic done;
  } raster_reply_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [CfgW-1:0] cfg_data;

  clr_cmd_if cmd_ch ();
  clr_res_if res_ch ();

  clipped_line_rasterizer DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cmd_i      (cmd_ch),
    .res_o      (res_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // Predictor state: its own framebuffer and copy of the screen size registers.
  bit frame_bits [FrameW*FrameH];
  logic [CfgW-1:0] scr_w = ScreenWidthReset;
  logic [CfgW-1:0] scr_h = ScreenHeightReset;

  raster_cmd_t cmd_queue [$];
  raster_reply_t pixel_replies [$];
  raster_cmd_t cur_cmd;
  bit cmd_held = 1'b0;
  int src_idle_pct = 0;
  int sink_idle_pct = 0;
  int mismatch_count = 0;

  // Endpoints of the most recent random line, used to aim pixel reads at it.
  int last_x0 = 0, last_y0 = 0, last_x1 = 0, last_y1 = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit in_view(int x, int y);
    int w, h;
    w = (int'(scr_w) < FrameW) ? int'(scr_w) : FrameW;
    h = (int'(scr_h) < FrameH) ? int'(scr_h) : FrameH;
    return x >= 0 && x < w && y >= 0 && y < h;
  endfunction

  function automatic void mark_pixel(int x, int y);
    if (in_view(x, y)) frame_bits[x + y * FrameW] = 1'b1;
  endfunction

  // Bresenham walk: x steps while the error is at most 2a-b, y steps when the
  // error reaches a or the line is steep. Off-screen pixels are dropped.
  function automatic void trace_line(int x0, int y0, int x1, int y1);
    int stx, sty;
    longint a, b, err, crit, left;
    stx = 1;
    sty = 1;
    a = longint'(x1) - longint'(x0);
    b = longint'(y1) - longint'(y0);
    err = 0;
    if (a < 0) begin
      stx = -1;
      a = -a;
    end
    if (b < 0) begin
      sty = -1;
      b = -b;
    end
    crit = 2 * a - b;
    left = a + b + 1;
    while (left > 0) begin
      left--;
      mark_pixel(x0, y0);
      if (x0 == x1 && y0 == y1) begin
        left = 0;
      end else begin
        if (err <= crit) begin
          x0 += stx;
          err += 2 * b;
        end
        if (err >= a || a < b) begin
          y0 += sty;
          err -= 2 * a;
        end
      end
    end
  endfunction

  // Applies one command to the predicted framebuffer and returns its reply.
  function automatic raster_reply_t rasterize_command(raster_cmd_t c);
    raster_reply_t r;
    int px, py;
    px = $signed(c.sx);
    py = $signed(c.sy);
    r.pixel = 1'b0;
    r.done = 1'b1;
    case (c.cmd)
      CMD_SET_POINT: mark_pixel(px, py);
      CMD_DRAW_LINE: trace_line(px, py, $signed(c.ex), $signed(c.ey));
      CMD_CLEAR_ALL: begin
        for (int i = 0; i < FrameW * FrameH; i++) frame_bits[i] = 1'b0;
      end
      default: begin
        if (in_view(px, py)) r.pixel = frame_bits[px + py * FrameW];
      end
    endcase
    return r;
  endfunction

  function automatic int clamp16(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic int near_coord();
    return int'($urandom_range(0, 300)) - 20;
  endfunction

  // Mostly near the screen, sometimes anywhere in the 16-bit range, sometimes an edge value.
  function automatic int rand_coord();
    int pick;
    logic signed [CoordW-1:0] v;
    pick = $urandom_range(99);
    v = CoordW'($urandom);
    if (pick < 88) return near_coord();
    if (pick < 97) return v;
    case ($urandom_range(3))
      0: return -32768;
      1: return 32767;
      2: return FrameW;
      default: return FrameW - 1;
    endcase
  endfunction

  task automatic queue_command(clr_cmd_e op, int x0, int y0, int x1, int y1);
    raster_cmd_t c;
    c.cmd = op;
    c.sx = CoordW'(x0);
    c.sy = CoordW'(y0);
    c.ex = CoordW'(x1);
    c.ey = CoordW'(y1);
    cmd_queue.push_back(c);
  endtask

  // Random command mix; reads often aim at or next to the last line drawn.
  task automatic queue_random_command();
    int pick, x0, y0, x1, y1, t;
    pick = $urandom_range(99);
    x0 = rand_coord();
    y0 = rand_coord();
    x1 = $signed(CoordW'($urandom));
    y1 = $signed(CoordW'($urandom));
    if (pick < 20) begin
      queue_command(CMD_SET_POINT, x0, y0, x1, y1);
    end else if (pick < 55) begin
      if ($urandom_range(9) == 0) begin
        x0 = near_coord();
        y0 = near_coord();
        x1 = near_coord();
        y1 = near_coord();
      end else begin
        x1 = clamp16(x0 + int'($urandom_range(0, 80)) - 40);
        y1 = clamp16(y0 + int'($urandom_range(0, 80)) - 40);
      end
      last_x0 = x0;
      last_y0 = y0;
      last_x1 = x1;
      last_y1 = y1;
      queue_command(CMD_DRAW_LINE, x0, y0, x1, y1);
    end else if (pick < 58) begin
      queue_command(CMD_CLEAR_ALL, x0, y0, x1, y1);
    end else begin
      if ($urandom_range(1) == 1) begin
        t = $urandom_range(0, 4);
        x0 = clamp16(last_x0 + (last_x1 - last_x0) * t / 4 + int'($urandom_range(0, 2)) - 1);
        y0 = clamp16(last_y0 + (last_y1 - last_y0) * t / 4 + int'($urandom_range(0, 2)) - 1);
      end
      queue_command(CMD_READ_PIXEL, x0, y0, x1, y1);
    end
  endtask

  // Both size registers in consecutive cycles; no command is in flight here.
  task automatic write_screen_size(logic [CfgW-1:0] w, logic [CfgW-1:0] h);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= RegScreenWidth;
    cfg_data <= w;
    scr_w = w;
    @(negedge clk);
    cfg_idx <= RegScreenHeight;
    cfg_data <= h;
    scr_h = h;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    while (cmd_queue.size() != 0 || cmd_held || pixel_replies.size() != 0) @(posedge clk);
  endtask

  task automatic log_mismatch(string what, raster_reply_t want, logic got_pix, logic got_done);
    mismatch_count++;
    if (mismatch_count <= MaxReports)
      $display("%0t: %s: expected pixel_value=%0b done_res=%0b, got pixel_value=%0b done_res=%0b",
               $time, what, want.pixel, want.done, got_pix, got_done);
  endtask

  // Command driver: presents the next queued command at the falling edge.
  always @(negedge clk) begin
    if (rst_n && !cmd_held) begin
      if (cmd_queue.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
        cur_cmd = cmd_queue.pop_front();
        cmd_held = 1'b1;
        cmd_ch.valid <= 1'b1;
        cmd_ch.command <= cur_cmd.cmd;
        cmd_ch.start_x <= cur_cmd.sx;
        cmd_ch.start_y <= cur_cmd.sy;
        cmd_ch.end_x <= cur_cmd.ex;
        cmd_ch.end_y <= cur_cmd.ey;
      end else begin
        cmd_ch.valid <= 1'b0;
      end
    end
  end

  // A command transaction updates the predictor and queues its reply.
  always @(posedge clk) begin
    if (rst_n && cmd_ch.valid && cmd_ch.ready) begin
      pixel_replies.push_back(rasterize_command(cur_cmd));
      cmd_held = 1'b0;
    end
  end

  // Result backpressure.
  always @(negedge clk) begin
    res_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
  end

  // Result monitor: each reply transaction is checked against the oldest prediction.
  always @(posedge clk) begin : check_replies
    raster_reply_t want;
    if (rst_n && res_ch.valid && res_ch.ready) begin
      if (pixel_replies.size() == 0) begin
        log_mismatch("reply with no command pending", '0, res_ch.pixel_value, res_ch.done_res);
      end else begin
        want = pixel_replies.pop_front();
        if (res_ch.pixel_value !== want.pixel || res_ch.done_res !== want.done)
          log_mismatch("reply mismatch", want, res_ch.pixel_value, res_ch.done_res);
      end
    end
  end

  // Watchdog on the whole run.
  initial begin
    repeat (CycleLimit) @(posedge clk);
    $display("tb_top: errors");
    $finish;
  end

  initial begin : stimulus
    int phase_w [NumPhases]     = '{256, 100, 511, 0, 1, 200};
    int phase_h [NumPhases]     = '{256, 37, 300, 256, 1, 256};
    int phase_items [NumPhases] = '{170, 150, 170, 60, 60, 250};
    int phase_src [NumPhases]   = '{31, 31, 78, 78, 0, 0};
    int phase_sink [NumPhases]  = '{78, 78, 31, 31, 0, 0};

    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = RegScreenWidth;
    cfg_data = '0;
    cmd_ch.valid = 1'b0;
    cmd_ch.command = CMD_SET_POINT;
    cmd_ch.start_x = '0;
    cmd_ch.start_y = '0;
    cmd_ch.end_x = '0;
    cmd_ch.end_y = '0;
    res_ch.ready = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int p = 0; p < NumPhases; p++) begin
      src_idle_pct = phase_src[p];
      sink_idle_pct = phase_sink[p];
      write_screen_size(CfgW'(phase_w[p]), CfgW'(phase_h[p]));

      if (p == 0) begin
        // Directed: fresh store, corners, clipping, extreme coordinates, line shapes.
        queue_command(CMD_READ_PIXEL, 0, 0, -1, -1);
        queue_command(CMD_SET_POINT, 0, 0, 0, 0);
        queue_command(CMD_READ_PIXEL, 0, 0, 0, 0);
        queue_command(CMD_SET_POINT, 255, 255, -1, -1);
        queue_command(CMD_READ_PIXEL, 255, 255, 0, 0);
        queue_command(CMD_SET_POINT, 256, 10, 0, 0);
        queue_command(CMD_READ_PIXEL, 256, 10, -1, -1);
        queue_command(CMD_READ_PIXEL, -1, 0, 0, 0);
        queue_command(CMD_SET_POINT, -32768, -32768, 32767, 32767);
        queue_command(CMD_SET_POINT, 32767, 32767, -32768, -32768);
        queue_command(CMD_READ_PIXEL, 32767, -32768, 0, 0);
        queue_command(CMD_DRAW_LINE, 0, 10, 20, 10);
        queue_command(CMD_DRAW_LINE, 5, 0, 5, 30);
        queue_command(CMD_DRAW_LINE, 30, 30, 25, 0);
        queue_command(CMD_DRAW_LINE, 60, 40, 20, 45);
        queue_command(CMD_DRAW_LINE, 7, 7, 7, 7);
        queue_command(CMD_DRAW_LINE, -32768, 5, 32767, 5);
        queue_command(CMD_DRAW_LINE, -32768, -32768, 32767, 32767);
        queue_command(CMD_READ_PIXEL, 128, 5, 0, 0);
        queue_command(CMD_READ_PIXEL, 100, 100, 0, 0);
        queue_command(CMD_READ_PIXEL, 27, 15, 0, 0);
        queue_command(CMD_CLEAR_ALL, -1, -1, -1, -1);
        queue_command(CMD_READ_PIXEL, 128, 5, 0, 0);
      end

      for (int n = 0; n < phase_items[p]; n++) queue_random_command();
      wait_drained();
    end

    repeat (DrainCycles) @(posedge clk);
    if (mismatch_count == 0 && pixel_replies.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/clr_pkg.sv
hw/rtl/clr_if.sv
hw/rtl/clipped_line_rasterizer.sv
tb/tb_top.sv
